// ===== design/qocr_pkg.sv =====
// ----------------------------------------------------------------------------
// qocr_pkg
// Shared widths, constants and the root step for the quaternion rebuild.
// ----------------------------------------------------------------------------
package qocr_pkg;

   localparam int COMP_W   = 16;
   localparam int OUT_W    = 15;
   localparam int SQ_W     = 31;
   localparam int SUM_W    = 33;
   localparam int RAD_W    = 32;
   localparam int ROOT_W   = 16;
   localparam int REM_W    = 18;
   localparam int ROOT_STG = 8;
   localparam int NUM_STG  = ROOT_STG + 2;

   localparam logic [SUM_W-1:0] UNIT_SQUARED = 33'd1073676289;

   localparam logic OP_XYZ = 1'b0;
   localparam logic OP_X   = 1'b1;

   typedef struct packed {
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
   } comp_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } root_step_type;

   // one digit pair of the restoring square root
   function automatic root_step_type root_step(input logic [REM_W-1:0]  rem,
                                               input logic [ROOT_W-1:0] root,
                                               input logic [1:0]        pair);
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      root_step_type    r;
      acc   = {rem, pair};
      trial = {{(REM_W-ROOT_W){1'b0}}, root, 2'b01};
      if (acc >= trial) begin
         r.rem  = REM_W'(acc - trial);
         r.root = {root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = acc[REM_W-1:0];
         r.root = {root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== design/quat_omitted_component_rebuild.sv =====
// ----------------------------------------------------------------------------
// quat_omitted_component_rebuild
// Rebuilds the omitted quaternion component as the rounded root of the unit square minus
// the given squares (clamped at zero); passes the given components through, y and z as zero for OP_X.
// Throughput: one word per cycle while no result word is stalled; 8-stage two-digit root pipeline.
// The whole pipeline holds while a result word is stalled.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module quat_omitted_component_rebuild
   import qocr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic signed [COMP_W-1:0] req_comp_x,
   input  logic signed [COMP_W-1:0] req_comp_y,
   input  logic signed [COMP_W-1:0] req_comp_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [COMP_W-1:0] rsp_out_x,
   output logic signed [COMP_W-1:0] rsp_out_y,
   output logic signed [COMP_W-1:0] rsp_out_z,
   output logic [OUT_W-1:0]         rsp_rebuilt
);

   logic                advance;
   logic [NUM_STG-1:0]  vld_ff;
   comp_type            comp_ff [NUM_STG];
   comp_type            comp_in;

   logic [SQ_W-1:0]     sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]     sq_x_in, sq_y_in, sq_z_in;
   logic [RAD_W-1:0]    rad0_ff;
   logic [RAD_W-1:0]    rad0_in;

   logic [RAD_W-1:0]    rad_ff  [ROOT_STG];
   logic [REM_W-1:0]    rem_ff  [ROOT_STG];
   logic [ROOT_W-1:0]   root_ff [ROOT_STG];
   logic [RAD_W-1:0]    rad_in  [ROOT_STG];
   logic [REM_W-1:0]    rem_in  [ROOT_STG];
   logic [ROOT_W-1:0]   root_in [ROOT_STG];

   logic                rsp_valid_ff;
   comp_type            rsp_comp_ff;
   logic [OUT_W-1:0]    rsp_rebuilt_ff;
   logic [OUT_W-1:0]    rsp_rebuilt_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // stage 0: squares
   always_comb begin
      logic signed [2*COMP_W-1:0] px, py, pz;
      comp_in.x = req_comp_x;
      comp_in.y = (req_operation == OP_XYZ) ? req_comp_y : '0;
      comp_in.z = (req_operation == OP_XYZ) ? req_comp_z : '0;
      px        = comp_in.x * comp_in.x;
      py        = comp_in.y * comp_in.y;
      pz        = comp_in.z * comp_in.z;
      sq_x_in   = px[SQ_W-1:0];
      sq_y_in   = py[SQ_W-1:0];
      sq_z_in   = pz[SQ_W-1:0];
   end

   // stage 1: difference, clamped at zero
   always_comb begin
      logic [SUM_W-1:0] diff;
      diff = UNIT_SQUARED - SUM_W'(sq_x_ff) - SUM_W'(sq_y_ff) - SUM_W'(sq_z_ff);
      if (diff[SUM_W-1] || diff == '0) begin
         rad0_in = '0;
      end else begin
         rad0_in = diff[RAD_W-1:0];
      end
   end

   // root stages: two digits each
   always_comb begin
      root_step_type    a, b;
      logic [RAD_W-1:0]  src_rad;
      logic [REM_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_root;
      for (int k = 0; k < ROOT_STG; k++) begin
         if (k == 0) begin
            src_rad  = rad0_ff;
            src_rem  = '0;
            src_root = '0;
         end else begin
            src_rad  = rad_ff[k-1];
            src_rem  = rem_ff[k-1];
            src_root = root_ff[k-1];
         end
         a          = root_step(src_rem, src_root, src_rad[RAD_W-1:RAD_W-2]);
         b          = root_step(a.rem, a.root, src_rad[RAD_W-3:RAD_W-4]);
         rem_in[k]  = b.rem;
         root_in[k] = b.root;
         rad_in[k]  = {src_rad[RAD_W-5:0], 4'b0000};
      end
   end

   // rounding
   assign rsp_rebuilt_in =
      OUT_W'(root_ff[ROOT_STG-1] +
             ROOT_W'(rem_ff[ROOT_STG-1] > REM_W'(root_ff[ROOT_STG-1])));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[NUM_STG-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NUM_STG-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         comp_ff[0] <= comp_in;
         for (int s = 1; s < NUM_STG; s++) begin
            comp_ff[s] <= comp_ff[s-1];
         end
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_z_ff <= sq_z_in;
         rad0_ff <= rad0_in;
         for (int k = 0; k < ROOT_STG; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
         rsp_comp_ff    <= comp_ff[NUM_STG-1];
         rsp_rebuilt_ff <= rsp_rebuilt_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_x   = rsp_comp_ff.x;
   assign rsp_out_y   = rsp_comp_ff.y;
   assign rsp_out_z   = rsp_comp_ff.z;
   assign rsp_rebuilt = rsp_rebuilt_ff;

`ifndef SYNTH
   a_stall_only_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result word");

   a_pipe_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(vld_ff) && $stable(rsp_valid_ff)))
      else $error("pipeline valid bits moved during stall");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_STG-1] |-> !root_ff[ROOT_STG-1][ROOT_W-1])
      else $error("root exceeds result range");
`endif

endmodule
